// ----- rtl/core/jdqt_pkg.sv -----
// Shared types and constants of the JPEG DQT header parser.
`default_nettype none
package jdqt_pkg;

    // Default parameter values
    localparam int LENGTH_BITS_DEF = 16;
    localparam int MAX_TABLES_DEF  = 3;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 16;
    localparam int LEN_FIELD_W = 16;
    localparam int TABLE_ID_W  = 2;
    localparam int ENTRY_W     = 6;
    localparam int PREC_W      = 4;
    localparam int ERR_W       = 3;
    localparam int TABLES_W    = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam int TABLE_ENTRIES = 64;

    // Marker codes
    localparam logic [BYTE_W-1:0] MARKER_PREFIX = 8'hFF;
    localparam logic [BYTE_W-1:0] MARKER_SOS    = 8'hDA;
    localparam logic [BYTE_W-1:0] MARKER_DQT    = 8'hDB;
    localparam logic [BYTE_W-1:0] NIBBLE_MASK   = 8'h0F;

    // A marker needs itself plus three more header bytes
    localparam int MARKER_ROOM = 4;

    // Divisibility by 65 of a 16-bit value: x * inv(65) mod 2^16 lands at or
    // below floor(65535/65) exactly when 65 divides x.
    localparam logic [LEN_FIELD_W-1:0] GROUP_INV   = 16'd4033;
    localparam logic [LEN_FIELD_W-1:0] GROUP_QUOT_MAX =
        LEN_FIELD_W'(65535 / (TABLE_ENTRIES + 1));

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_OVERRUN   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_LEN   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_TYPE  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NO_TABLES = 3'd4;

    typedef enum logic [6:0] {
        MODE_SEEK   = 7'b0000001,
        MODE_MARKER = 7'b0000010,
        MODE_LEN_HI = 7'b0000100,
        MODE_LEN_LO = 7'b0001000,
        MODE_TYPE   = 7'b0010000,
        MODE_ENTRY  = 7'b0100000,
        MODE_DONE   = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic              first_byte;
    } t_in_beat;

    typedef struct packed {
        logic                  write_valid;
        logic [TABLE_ID_W-1:0] table_id;
        logic [ENTRY_W-1:0]    entry_index;
        logic [BYTE_W-1:0]     entry_value;
        logic [PREC_W-1:0]     table_precision;
        logic                  finished;
        logic [ERR_W-1:0]      error_code;
        logic [TABLES_W-1:0]   tables_found;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/core/jdqt_in_stage.sv -----
// Input register stage of the DQT parser.
`default_nettype none
module jdqt_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  jdqt_pkg::t_in_beat  i_beat,
    input  wire                 i_advance,
    output logic                o_valid,
    output jdqt_pkg::t_in_beat  o_beat
);
    import jdqt_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;

    // Take a new beat when empty or when the held one moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule
`default_nettype wire

// ----- rtl/core/jdqt_parse_core.sv -----
// Parse state and byte-wise next-state logic of the DQT parser.
`default_nettype none
module jdqt_parse_core #(
    parameter int LENGTH_BITS = jdqt_pkg::LENGTH_BITS_DEF,
    parameter int MAX_TABLES  = jdqt_pkg::MAX_TABLES_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_advance,
    input  jdqt_pkg::t_in_beat     i_beat,
    input  wire [LENGTH_BITS-1:0]  i_header_length,
    output jdqt_pkg::t_result      o_result
);
    import jdqt_pkg::*;

    localparam int CNT_W = $clog2(MAX_TABLES + 1);
    localparam int SEG_W = ((LENGTH_BITS > LEN_FIELD_W) ? LENGTH_BITS : LEN_FIELD_W) + 1;
    localparam logic [CNT_W:0] MAX_CNT  = (CNT_W + 1)'(MAX_TABLES);
    localparam logic [3:0]     MAX_TYPE = 4'(MAX_TABLES);

    t_mode                  r_mode, n_mode, c_mode;
    logic [LENGTH_BITS-1:0] r_pos, n_pos, c_pos;
    logic [LEN_FIELD_W-1:0] r_seg_left, n_seg_left, c_seg_left;
    logic [BYTE_W-1:0]      r_len_hi, n_len_hi, c_len_hi;
    logic [TABLE_ID_W-1:0]  r_table, n_table, c_table;
    logic [PREC_W-1:0]      r_prec, n_prec, c_prec;
    logic [ENTRY_W-1:0]     r_entry, n_entry, c_entry;
    logic [CNT_W-1:0]       r_count, n_count, c_count;
    logic [ERR_W-1:0]       r_err, n_err, c_err;

    logic [BYTE_W-1:0]      b;
    logic                   end_now;
    logic [LENGTH_BITS-1:0] room;
    logic [LENGTH_BITS:0]   pos_inc;
    logic [LEN_FIELD_W-1:0] seg_len;
    logic [LEN_FIELD_W-1:0] seg_body;
    logic [LEN_FIELD_W-1:0] seg_test;
    logic [SEG_W-1:0]       seg_end;
    logic [LEN_FIELD_W-1:0] seg_dec;
    logic [CNT_W:0]         cnt_inc;
    t_result                res;

    always_comb begin
        b = i_beat.header_byte;

        // A first byte restarts from the cleared state
        if (i_beat.first_byte) begin
            c_mode     = MODE_SEEK;
            c_pos      = '0;
            c_seg_left = '0;
            c_len_hi   = '0;
            c_table    = '0;
            c_prec     = '0;
            c_entry    = '0;
            c_count    = '0;
            c_err      = ERR_NONE;
        end else begin
            c_mode     = r_mode;
            c_pos      = r_pos;
            c_seg_left = r_seg_left;
            c_len_hi   = r_len_hi;
            c_table    = r_table;
            c_prec     = r_prec;
            c_entry    = r_entry;
            c_count    = r_count;
            c_err      = r_err;
        end

        n_mode     = c_mode;
        n_pos      = c_pos;
        n_seg_left = c_seg_left;
        n_len_hi   = c_len_hi;
        n_table    = c_table;
        n_prec     = c_prec;
        n_entry    = c_entry;
        n_count    = c_count;
        n_err      = c_err;
        end_now    = 1'b0;

        room     = i_header_length - c_pos;
        pos_inc  = {1'b0, c_pos} + (LENGTH_BITS + 1)'(1);
        seg_len  = {c_len_hi, b};
        seg_body = seg_len - LEN_FIELD_W'(2);
        seg_test = LEN_FIELD_W'(seg_body * GROUP_INV);
        seg_end  = SEG_W'(c_pos - LENGTH_BITS'(1)) + SEG_W'(seg_len);
        seg_dec  = c_seg_left - LEN_FIELD_W'(1);
        cnt_inc  = {1'b0, c_count} + (CNT_W + 1)'(1);

        res = '0;

        if (c_mode != MODE_DONE) begin
            if (c_pos >= i_header_length) begin
                end_now = 1'b1;
            end else begin
                unique case (c_mode)
                    MODE_SEEK: begin
                        if (b == MARKER_PREFIX) begin
                            if (room < LENGTH_BITS'(MARKER_ROOM)) end_now = 1'b1;
                            else n_mode = MODE_MARKER;
                        end
                    end
                    MODE_MARKER: begin
                        if (b == MARKER_SOS)      end_now = 1'b1;
                        else if (b == MARKER_DQT) n_mode = MODE_LEN_HI;
                        else                      n_mode = MODE_SEEK;
                    end
                    MODE_LEN_HI: begin
                        n_len_hi = b;
                        n_mode   = MODE_LEN_LO;
                    end
                    MODE_LEN_LO: begin
                        // overrun is checked ahead of the length rule
                        if (seg_end > SEG_W'(i_header_length)) begin
                            n_err   = ERR_OVERRUN;
                            end_now = 1'b1;
                        end else if (seg_len[LEN_FIELD_W-1:1] == '0 ||
                                     seg_test > GROUP_QUOT_MAX) begin
                            n_err   = ERR_BAD_LEN;
                            end_now = 1'b1;
                        end else begin
                            n_seg_left = seg_body;
                            n_mode     = (seg_body != '0) ? MODE_TYPE : MODE_SEEK;
                        end
                    end
                    MODE_TYPE: begin
                        n_seg_left = seg_dec;
                        n_prec     = b[BYTE_W-1:PREC_W];
                        if ((b & NIBBLE_MASK) >= {4'b0, MAX_TYPE}) begin
                            n_err   = ERR_BAD_TYPE;
                            end_now = 1'b1;
                        end else begin
                            n_table = b[TABLE_ID_W-1:0];
                            n_entry = '0;
                            n_mode  = MODE_ENTRY;
                        end
                    end
                    MODE_ENTRY: begin
                        n_seg_left          = seg_dec;
                        res.write_valid     = 1'b1;
                        res.table_id        = c_table;
                        res.entry_index     = c_entry;
                        res.entry_value     = b;
                        res.table_precision = c_prec;
                        if (c_entry == ENTRY_W'(TABLE_ENTRIES - 1)) begin
                            n_count = cnt_inc[CNT_W-1:0];
                            if (cnt_inc >= MAX_CNT) end_now = 1'b1;
                            else n_mode = (seg_dec != '0) ? MODE_TYPE : MODE_SEEK;
                        end else begin
                            n_entry = c_entry + ENTRY_W'(1);
                        end
                    end
                    default: end_now = 1'b1;
                endcase

                // last header byte seen while hunting for markers
                if (!end_now && n_mode == MODE_SEEK && pos_inc >= {1'b0, i_header_length})
                    end_now = 1'b1;
                if (!end_now)
                    n_pos = pos_inc[LENGTH_BITS-1:0];
            end
        end

        if (end_now) begin
            n_mode = MODE_DONE;
            if (n_err == ERR_NONE && n_count == '0)
                n_err = ERR_NO_TABLES;
        end

        res.finished     = (n_mode == MODE_DONE);
        res.error_code   = n_err;
        res.tables_found = TABLES_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_SEEK;
            r_pos      <= '0;
            r_seg_left <= '0;
            r_len_hi   <= '0;
            r_table    <= '0;
            r_prec     <= '0;
            r_entry    <= '0;
            r_count    <= '0;
            r_err      <= ERR_NONE;
        end else if (i_advance) begin
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_seg_left <= n_seg_left;
            r_len_hi   <= n_len_hi;
            r_table    <= n_table;
            r_prec     <= n_prec;
            r_entry    <= n_entry;
            r_count    <= n_count;
            r_err      <= n_err;
        end
    end

    assign o_result = res;

`ifndef ASSERT_OFF
    a_err_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |-> (r_mode == MODE_DONE))
        else $error("error status set while parse still running");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_DONE && i_advance && !i_beat.first_byte)
        |=> (r_mode == MODE_DONE && $stable(r_pos) && $stable(r_err) && $stable(r_count)))
        else $error("finished parse changed without a restart");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} <= MAX_CNT))
        else $error("table count beyond table limit");

    a_write_table_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && res.write_valid) |-> ({2'b0, res.table_id} < MAX_TYPE))
        else $error("table entry written for an out of range table");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/jdqt_out_stage.sv -----
// Result register stage of the DQT parser.
`default_nettype none
module jdqt_out_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  jdqt_pkg::t_result   i_result,
    input  wire                 i_ready,
    output logic                o_advance,
    output logic                o_valid,
    output jdqt_pkg::t_result   o_result
);
    import jdqt_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    free;

    assign free      = !r_valid || i_ready;
    assign o_advance = i_in_valid && free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (free) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ----- rtl/core/jpeg_dqt_header_parser_unit.sv -----
// JPEG DQT header parser: one result beat for every header byte beat.
//
// Input stream (s_axis): one header byte per beat; tuser[0] set marks the
// first byte of a new header and restarts the parse from position 0.
// Output stream (m_axis): one result beat per input beat, in order. tuser[0]
// flags a quantization table entry write; tdata carries the table id, entry
// index, entry value, precision, finished flag, error code and table count.
// Configuration: i_cfg_wr_en with i_cfg_wr_data loads the header length;
// write it only while no beat is in flight.
// A byte held in the input register passes the parse step and is registered
// in the result register, which drives m_axis, once the result register is free.
// Throughput is one beat per cycle while m_axis_tready keeps the result register
// free; the parse step between the input and result registers is combinational.
// A stalled receiver holds the result register; the input register still
// takes one more beat, then s_axis_tready drops until the result moves.
// Reset clears the valid flags of both register stages, the parse state and the header
// length (zero), so a byte streamed before configuration ends the parse.
`default_nettype none
module jpeg_dqt_header_parser_unit #(
    parameter int LENGTH_BITS = jdqt_pkg::LENGTH_BITS_DEF,
    parameter int MAX_TABLES  = jdqt_pkg::MAX_TABLES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire [jdqt_pkg::CFG_W-1:0]          i_cfg_wr_data,  // header_length
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire [jdqt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [7:0] header_byte
    input  wire [0:0]                          s_axis_tuser,   // [0] first_byte
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [1:0] table_id, [7:2] entry_index, [15:8] entry_value,
    // [19:16] table_precision, [20] finished, [23:21] error_code,
    // [25:24] tables_found, [31:26] zero
    output logic [jdqt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [0:0]                         m_axis_tuser    // [0] write_valid
);
    import jdqt_pkg::*;

    localparam int RES_DATA_W = TABLE_ID_W + ENTRY_W + BYTE_W + PREC_W + 1 + ERR_W + TABLES_W;

    logic [LENGTH_BITS-1:0] r_header_length;
    t_in_beat               in_beat, held_beat;
    logic                   held_valid;
    logic                   advance;
    t_result                step_result, out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_length <= '0;
        end else if (i_cfg_wr_en) begin
            r_header_length <= LENGTH_BITS'(i_cfg_wr_data);
        end
    end

    assign in_beat.header_byte = s_axis_tdata[BYTE_W-1:0];
    assign in_beat.first_byte  = s_axis_tuser[0];

    jdqt_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_beat    (in_beat),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_beat    (held_beat)
    );

    jdqt_parse_core #(
        .LENGTH_BITS (LENGTH_BITS),
        .MAX_TABLES  (MAX_TABLES)
    ) u_parse_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_beat          (held_beat),
        .i_header_length (r_header_length),
        .o_result        (step_result)
    );

    jdqt_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (held_valid),
        .i_result   (step_result),
        .i_ready    (m_axis_tready),
        .o_advance  (advance),
        .o_valid    (m_axis_tvalid),
        .o_result   (out_result)
    );

    assign m_axis_tuser[0] = out_result.write_valid;
    assign m_axis_tdata = {
        (OUT_TDATA_W - RES_DATA_W)'(0),
        out_result.tables_found,
        out_result.error_code,
        out_result.finished,
        out_result.table_precision,
        out_result.entry_value,
        out_result.entry_index,
        out_result.table_id
    };

endmodule
`default_nettype wire
